FILE: hdl/wsu_pkg.sv
package wsu_pkg;

    // Parser phase codes
    localparam logic [2:0] PH_FIRST = 3'd0;
    localparam logic [2:0] PH_LEN   = 3'd1;
    localparam logic [2:0] PH_EXT   = 3'd2;
    localparam logic [2:0] PH_KEY   = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_OTHER = 3'd5;

    // Header byte values and fields
    localparam logic [7:0] FIN_BIT       = 8'h80;
    localparam logic [3:0] TYPE_TEXT     = 4'd1;
    localparam logic [3:0] TYPE_CLOSE    = 4'd8;
    localparam logic [7:0] FIRST_TEXT    = FIN_BIT | {4'h0, TYPE_TEXT};
    localparam logic [7:0] FIRST_CLOSE   = FIN_BIT | {4'h0, TYPE_CLOSE};
    localparam logic [6:0] LEN_EXT16     = 7'd126;
    localparam logic [6:0] LEN_EXT64     = 7'd127;
    localparam logic [3:0] SKIP_EXT16    = 4'd2;
    localparam logic [3:0] SKIP_EXT64    = 4'd8;
    localparam logic [1:0] KEY_LAST_IDX  = 2'd3;

    // One result word
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       has_byte;
        logic [3:0] frame_type;
        logic       frame_done;
        logic       truncated;
    } wsu_result_t;

endpackage

FILE: hdl/wsu_if.sv
interface wsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface wsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       has_byte;
    logic [3:0] frame_type;
    logic       frame_done;
    logic       truncated;

    modport source (output valid, output payload_byte, output has_byte, output frame_type,
                    output frame_done, output truncated, input ready);
    modport sink   (input valid, input payload_byte, input has_byte, input frame_type,
                    input frame_done, input truncated, output ready);
endinterface

FILE: hdl/wsu_parser.sv
module wsu_parser
    import wsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    input  logic        step,
    output logic        emit,
    output wsu_result_t res
);

    logic [2:0]      phase_reg, phase_next;
    logic [3:0]      skip_reg, skip_next;
    logic [1:0]      kidx_reg, kidx_next;
    logic [3:0]      type_reg, type_next;
    logic [3:0][7:0] key_reg, key_next;
    logic [3:0]      skip_dec;

    // Every frame end and every payload byte gives a result
    assign emit = in_last || (phase_reg == PH_DATA);

    assign skip_dec = (skip_reg != 4'd0) ? skip_reg - 4'd1 : 4'd0;

    // Decode one byte against the current phase
    always_comb
    begin
        phase_next = phase_reg;
        skip_next  = skip_reg;
        kidx_next  = kidx_reg;
        type_next  = type_reg;
        key_next   = key_reg;
        res        = '{payload_byte: 8'h00, has_byte: 1'b0, frame_type: TYPE_TEXT,
                       frame_done: 1'b1, truncated: 1'b1};
        unique case (phase_reg)
            PH_FIRST:
            begin
                if (in_byte == FIRST_TEXT)
                begin
                    type_next  = TYPE_TEXT;
                    phase_next = PH_LEN;
                end
                else
                begin
                    type_next     = (in_byte == FIRST_CLOSE) ? TYPE_CLOSE : in_byte[3:0];
                    res.frame_type = type_next;
                    res.truncated  = 1'b0;
                    phase_next     = PH_OTHER;
                end
            end
            PH_LEN:
            begin
                kidx_next = 2'd0;
                if (in_byte[6:0] == LEN_EXT16)
                begin
                    skip_next  = SKIP_EXT16;
                    phase_next = PH_EXT;
                end
                else if (in_byte[6:0] == LEN_EXT64)
                begin
                    skip_next  = SKIP_EXT64;
                    phase_next = PH_EXT;
                end
                else
                begin
                    skip_next  = 4'd0;
                    phase_next = PH_KEY;
                end
            end
            PH_EXT:
            begin
                skip_next = skip_dec;
                if (skip_dec == 4'd0)
                begin
                    kidx_next  = 2'd0;
                    phase_next = PH_KEY;
                end
            end
            PH_KEY:
            begin
                key_next[kidx_reg] = in_byte;
                if (kidx_reg == KEY_LAST_IDX)
                begin
                    kidx_next     = 2'd0;
                    res.truncated = 1'b0;
                    phase_next    = PH_DATA;
                end
                else
                begin
                    kidx_next = kidx_reg + 2'd1;
                end
            end
            PH_DATA:
            begin
                res.payload_byte = in_byte ^ key_reg[kidx_reg];
                res.has_byte     = 1'b1;
                res.frame_done   = in_last;
                res.truncated    = 1'b0;
                kidx_next        = kidx_reg + 2'd1;
            end
            default:
            begin
                res.frame_type = type_reg;
                res.truncated  = 1'b0;
                phase_next     = PH_OTHER;
            end
        endcase

        // Return to idle on any frame end
        if (in_last)
        begin
            phase_next = PH_FIRST;
            skip_next  = 4'd0;
            kidx_next  = 2'd0;
        end
    end

    // Advance state on each consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            skip_reg  <= 4'd0;
            kidx_reg  <= 2'd0;
            type_reg  <= 4'd0;
            key_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
            kidx_reg  <= kidx_next;
            type_reg  <= type_next;
            key_reg   <= key_next;
        end
    end

endmodule

FILE: hdl/websocket_frame_unmasker.sv
// Receive-side WebSocket frame unmasker. Frame bytes enter on rx, one word per byte, with
// frame_end set on the last byte. Text frames (first byte 0x81) have their header, extended
// length and mask key stripped, and each payload byte leaves on result XORed with the key; the
// mask bit and length field are not checked, so the payload runs to frame_end. Other frames
// give a single type word at their end, and a text frame that ends inside its header gives a
// word with truncated set. The block takes one byte per cycle unless a byte that gives a result
// meets a result word still waiting to be taken; a byte passes through the input register and
// then the result register, with the header decode and XOR between them. Bytes that give no
// result keep flowing while a result word waits to be taken.
module websocket_frame_unmasker
    import wsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    wsu_in_if.sink    rx,
    wsu_out_if.source result
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    wsu_result_t out_res_reg;

    logic        emit;
    logic        out_free;
    logic        fire;
    wsu_result_t res;

    wsu_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .step    (fire),
        .emit    (emit),
        .res     (res)
    );

    // Consume the held byte unless its result has nowhere to go
    assign out_free = !out_valid_reg || result.ready;
    assign fire     = in_valid_reg && (!emit || out_free);
    assign rx.ready = !in_valid_reg || fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg <= rx.rx_byte;
            in_last_reg <= rx.frame_end;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            out_res_reg <= res;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.payload_byte = out_res_reg.payload_byte;
    assign result.has_byte     = out_res_reg.has_byte;
    assign result.frame_type   = out_res_reg.frame_type;
    assign result.frame_done   = out_res_reg.frame_done;
    assign result.truncated    = out_res_reg.truncated;

endmodule

FILE: hdl/wsu_checker.sv
module wsu_checker
    import wsu_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       has_byte,
    input logic [3:0] frame_type,
    input logic       frame_done,
    input logic       truncated
);

    // Hold a stalled result word
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // Payload words belong to text frames and are never truncated
    a_payload_text: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_byte |-> frame_type == TYPE_TEXT && !truncated)
        else $error("payload word with wrong type or truncated flag");

    // A word without data always closes the frame
    a_nodata_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> frame_done)
        else $error("word without data does not close a frame");

    // Truncation is reported only for text frames
    a_trunc_text: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && truncated |-> frame_type == TYPE_TEXT && !has_byte)
        else $error("truncated flag on a non-text or data word");

endmodule

bind websocket_frame_unmasker wsu_checker u_wsu_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .has_byte   (result.has_byte),
    .frame_type (result.frame_type),
    .frame_done (result.frame_done),
    .truncated  (result.truncated)
);
